[design/text_cell_pixel_generator_top_assert.svh]
// Assertion macros for the text cell pixel generator top level.
`ifndef TEXT_CELL_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define TEXT_CELL_PIXEL_GENERATOR_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define TCPG_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the following cycle.
`define TCPG_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[design/tcpg_pkg.sv]
// Shared types, constants and helper functions of the text cell pixel generator.
package tcpg_pkg;

  // Cell geometry and glyph store sizing
  localparam int CELL_HEIGHT = 16;
  localparam int NUM_BANKS   = 3;
  localparam int NUM_CODES   = 256;
  localparam int CELL_WIDTH  = 9;
  localparam int GLYPH_DEPTH = NUM_BANKS * NUM_CODES * CELL_HEIGHT;
  localparam int GA_W        = $clog2(GLYPH_DEPTH);
  localparam int CNT_W       = $clog2(CELL_WIDTH);
  localparam int ROWC_W      = 6;

  // Field widths
  localparam int OP_W    = 2;
  localparam int CODE_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int ROW_W   = 4;
  localparam int BANK_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int PIDX_W  = 4;
  localparam int COLOR_W = 32;
  localparam int PAL_DEPTH = 16;

  // Codes whose ninth column repeats the eighth (line-drawing range)
  localparam logic [CODE_W-1:0] DUP_CODE_LO = 8'hC0;
  localparam logic [CODE_W-1:0] DUP_CODE_HI = 8'hDF;

  typedef enum logic [OP_W-1:0] {
    OP_RENDER  = 2'd0,
    OP_LOAD    = 2'd1,
    OP_PALETTE = 2'd2
  } op_t;

  typedef logic [CELL_WIDTH-1:0] mask_t;
  typedef logic [COLOR_W-1:0]    color_t;

  // Standard 16-colour text palette
  localparam color_t IBM_COLORS [PAL_DEPTH] = '{
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
    32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
    32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF
  };

  // Build the nine-column mask from a font byte
  function automatic mask_t make_mask(input logic [CODE_W-1:0] code,
                                      input logic [BYTE_W-1:0] font);
    mask_t m;
    m = {font, 1'b0};
    if (code >= DUP_CODE_LO && code <= DUP_CODE_HI) begin
      m[0] = font[0];
    end
    return m;
  endfunction

  // Flat glyph store address of bank, code and row
  function automatic logic [GA_W-1:0] glyph_addr(input logic [BANK_W-1:0] bank,
                                                 input logic [CODE_W-1:0] code,
                                                 input logic [ROW_W-1:0]  row);
    return GA_W'(bank) * GA_W'(NUM_CODES * CELL_HEIGHT)
         + GA_W'(code) * GA_W'(CELL_HEIGHT)
         + GA_W'(row);
  endfunction

  // Row lies inside the cell
  function automatic logic row_ok(input logic [ROW_W-1:0] row);
    return ROWC_W'(row) < ROWC_W'(CELL_HEIGHT);
  endfunction

endpackage

[design/tcpg_if.sv]
// Channel interfaces of the text cell pixel generator: input items and pixel beats.
interface tcpg_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcpg_pkg::OP_W-1:0]    op;
  logic [tcpg_pkg::CODE_W-1:0]  char_code;
  logic [tcpg_pkg::ATTR_W-1:0]  attribute;
  logic [tcpg_pkg::ROW_W-1:0]   glyph_row;
  logic [tcpg_pkg::BANK_W-1:0]  load_bank;
  logic [tcpg_pkg::BYTE_W-1:0]  font_byte;
  logic [tcpg_pkg::PIDX_W-1:0]  palette_index;
  logic [tcpg_pkg::COLOR_W-1:0] palette_value;

  modport source (
    output valid, op, char_code, attribute, glyph_row, load_bank, font_byte,
           palette_index, palette_value,
    input  ready
  );
  modport sink (
    input  valid, op, char_code, attribute, glyph_row, load_bank, font_byte,
           palette_index, palette_value,
    output ready
  );
endinterface

interface tcpg_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcpg_pkg::COLOR_W-1:0] pixel_color;
  logic                         last_pixel;

  modport source (output valid, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_color, last_pixel, output ready);
endinterface

[design/text_cell_pixel_generator_top.sv]
// Top level of the text cell pixel generator: lookup pipeline and pixel serialiser.
//
//   channel   direction  handshake       beat
//   in_bus    sink       valid / ready   one render, glyph load or palette item
//   out_bus   source     valid / ready   one pixel colour, last_pixel on the ninth
//   cfg       sink       cfg_we          active glyph bank
//
// A render item yields nine pixel beats, one per cycle while out_bus is ready;
// the serialiser takes a new row only when empty or as its ninth beat is taken.
// Glyph loads and palette writes retire on acceptance and give no beats. A
// render item passes stage 1, stage 2 and the serialiser in order. Reset clears
// pipeline valids, the palette valid bits and the active bank; the glyph store
// is not cleared. A stalled output holds the serialiser; earlier stages hold when full.
module text_cell_pixel_generator_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tcpg_pkg::BANK_W-1:0]  cfg_data,
  tcpg_in_if.sink                      in_bus,
  tcpg_out_if.source                   out_bus
);
  import tcpg_pkg::*;

  `include "text_cell_pixel_generator_top_assert.svh"

  logic [BANK_W-1:0] active_bank_r;

  // Stage 1: memory read data and palette lookups
  logic              s1_valid_r;
  logic              s1_zero_r;
  color_t            s1_fg_raw_r;
  color_t            s1_bg_raw_r;
  logic              s1_fg_def_r;
  logic              s1_bg_def_r;
  logic [PIDX_W-1:0] s1_fg_idx_r;
  logic [PIDX_W-1:0] s1_bg_idx_r;
  mask_t             glyph_rdata;

  // Stage 2: resolved colours and mask
  logic   s2_valid_r;
  mask_t  s2_mask_r;
  color_t s2_fg_r;
  color_t s2_bg_r;

  // Stage 3: serialiser
  logic             s3_valid_r;
  mask_t            s3_mask_r;
  color_t           s3_fg_r;
  color_t           s3_bg_r;
  logic [CNT_W-1:0] s3_cnt_r;
  logic             s3_last;

  color_t                 pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0]   pal_valid_r;

  logic in_fire, out_fire, render_fire, load_fire, pal_fire;
  logic s3_free, s2_adv, s2_free, s1_adv;
  logic [PIDX_W-1:0] fg_idx, bg_idx;

  // Handshake and stage advance
  assign s3_last  = (s3_cnt_r == CNT_W'(CELL_WIDTH - 1));
  assign out_fire = out_bus.valid && out_bus.ready;
  assign s3_free  = !s3_valid_r || (out_fire && s3_last);
  assign s2_adv   = s2_valid_r && s3_free;
  assign s2_free  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_bus.ready = !s1_valid_r || s1_adv;

  assign in_fire     = in_bus.valid && in_bus.ready;
  assign render_fire = in_fire && (in_bus.op == OP_RENDER);
  assign load_fire   = in_fire && (in_bus.op == OP_LOAD)
                     && (in_bus.load_bank < BANK_W'(NUM_BANKS)) && row_ok(in_bus.glyph_row);
  assign pal_fire    = in_fire && (in_bus.op == OP_PALETTE);

  assign fg_idx = in_bus.attribute[PIDX_W-1:0];
  assign bg_idx = in_bus.attribute[ATTR_W-1:PIDX_W];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bank_r <= '0;
    end else if (cfg_we) begin
      active_bank_r <= cfg_data;
    end
  end

  // Glyph store
  tcpg_glyph_ram #(
    .DEPTH (GLYPH_DEPTH),
    .WIDTH (CELL_WIDTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (glyph_addr(in_bus.load_bank, in_bus.char_code, in_bus.glyph_row)),
    .wdata (make_mask(in_bus.char_code, in_bus.font_byte)),
    .re    (render_fire),
    .raddr (glyph_addr(active_bank_r, in_bus.char_code, in_bus.glyph_row)),
    .rdata (glyph_rdata)
  );

  // Palette storage; entries not yet written read as the standard colours
  always_ff @(posedge clk) begin
    if (pal_fire) begin
      pal_mem[in_bus.palette_index] <= in_bus.palette_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_valid_r <= '0;
    end else if (pal_fire) begin
      pal_valid_r[in_bus.palette_index] <= 1'b1;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= render_fire;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload: capture palette reads with the glyph read
  always_ff @(posedge clk) begin
    if (render_fire) begin
      s1_zero_r   <= (active_bank_r >= BANK_W'(NUM_BANKS)) || !row_ok(in_bus.glyph_row);
      s1_fg_raw_r <= pal_mem[fg_idx];
      s1_bg_raw_r <= pal_mem[bg_idx];
      s1_fg_def_r <= !pal_valid_r[fg_idx];
      s1_bg_def_r <= !pal_valid_r[bg_idx];
      s1_fg_idx_r <= fg_idx;
      s1_bg_idx_r <= bg_idx;
    end
  end

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Stage 2 payload: resolve colours and mask
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_mask_r <= s1_zero_r ? '0 : glyph_rdata;
      s2_fg_r   <= s1_fg_def_r ? IBM_COLORS[s1_fg_idx_r] : s1_fg_raw_r;
      s2_bg_r   <= s1_bg_def_r ? IBM_COLORS[s1_bg_idx_r] : s1_bg_raw_r;
    end
  end

  // Stage 3: serialise nine pixels, leftmost column first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s3_cnt_r   <= '0;
    end else if (s2_adv) begin
      s3_valid_r <= 1'b1;
      s3_cnt_r   <= '0;
    end else if (out_fire) begin
      s3_valid_r <= !s3_last;
      s3_cnt_r   <= s3_last ? '0 : s3_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_mask_r <= s2_mask_r;
      s3_fg_r   <= s2_fg_r;
      s3_bg_r   <= s2_bg_r;
    end else if (out_fire) begin
      s3_mask_r <= {s3_mask_r[CELL_WIDTH-2:0], 1'b0};
    end
  end

  assign out_bus.valid       = s3_valid_r;
  assign out_bus.pixel_color = s3_mask_r[CELL_WIDTH-1] ? s3_fg_r : s3_bg_r;
  assign out_bus.last_pixel  = s3_last;

  // A cell row is never cut short once it starts
  `TCPG_ASSERT_NEXT(a_row_continues, clk, rst_n, out_fire && !s3_last, s3_valid_r)
  // After the ninth beat, with no row waiting in stage 2, the serialiser goes idle
  `TCPG_ASSERT_NEXT(a_cnt_wraps, clk, rst_n, out_fire && s3_last && !s2_valid_r, !s3_valid_r)
  // Input stalls only behind a full, blocked first stage
  `TCPG_ASSERT_SAME(a_stall_cause, clk, rst_n, !in_bus.ready, s1_valid_r && s2_valid_r)
  // A palette write marks its entry as written
  `TCPG_ASSERT_NEXT(a_pal_mark, clk, rst_n, pal_fire, pal_valid_r[$past(in_bus.palette_index)])

endmodule

[design/tcpg_glyph_ram.sv]
// Simple dual-port RAM with registered read data, used as the glyph store.
module tcpg_glyph_ram #(
  parameter int DEPTH = 12288,
  parameter int WIDTH = 9,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: hold the last word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
